FILE: hdl/fnvd_pkg.sv
// ----------------------------------------------------------------------------
// fnvd_pkg
// Shared constants, datapath command/status types and FNV helper functions
// for the canonical FNV-1a digest block.
// ----------------------------------------------------------------------------
package fnvd_pkg;

    localparam int DATA_W        = 64;
    localparam int COUNT_W       = 4;
    localparam int IN_TDATA_W    = 72;
    localparam int OUT_TDATA_W   = 128;
    localparam int MAX_BYTES_DEF = 8;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
    localparam logic [63:0] ALT_BASIS = 64'h84222325CBF29CE4;
    localparam logic [63:0] MIX_MULT  = 64'hBF58476D1CE4E5B9;
    localparam int          MIX_SHIFT_A = 29;
    localparam int          MIX_SHIFT_B = 32;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ABSORB,
        OP_MIX,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
        logic last;
    } t_dp_sts;

    // Multiply by the FNV prime: 2^40 + 0x1B3, so a shift plus a narrow product.
    function automatic logic [63:0] fnv_mul_prime(input logic [63:0] x);
        logic [63:0] lo_part;
        lo_part = x * 64'h00000000000001B3;
        return (x << 40) + lo_part;
    endfunction

    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
        return fnv_mul_prime(h ^ {56'b0, b});
    endfunction

    function automatic logic [63:0] mix_pre(input logic [63:0] h);
        logic [63:0] t;
        t = fnv_mul_prime(h ^ ALT_BASIS);
        return t ^ (t >> MIX_SHIFT_A);
    endfunction

endpackage

FILE: hdl/fnvd_ctrl.sv
// ----------------------------------------------------------------------------
// fnvd_ctrl
// Sequencer for the digest block: accepts beats, steps byte absorption,
// runs the multi-cycle mix and owns the output valid.
// ----------------------------------------------------------------------------
module fnvd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  fnvd_pkg::t_dp_sts i_sts,
    output fnvd_pkg::t_dp_cmd o_cmd
);
    import fnvd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_MIX,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd.op    = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                if (!i_sts.cnt_zero) begin
                    o_cmd.op = OP_ABSORB;
                end
                if (i_sts.cnt_zero || i_sts.cnt_one) begin
                    n_state = i_sts.last ? ST_MIX : ST_IDLE;
                end
            end
            ST_MIX: begin
                o_cmd.op = OP_MIX;
                n_state  = ST_MUL0;
            end
            ST_MUL0: begin
                o_cmd.op = OP_MUL0;
                n_state  = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.op = OP_MUL1;
                n_state  = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.op = OP_MUL2;
                n_state  = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.op    = OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_FINISH) |-> out_free)
        else $error("digest written over a pending result");

    a_finish_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_FINISH) |=> r_out_valid)
        else $error("digest not presented after finish");

    a_accept_starts_absorb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_ABSORB))
        else $error("accepted beat not absorbed");

    a_absorb_needs_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_ABSORB) |-> !i_sts.cnt_zero)
        else $error("absorb issued with no bytes left");

endmodule

FILE: hdl/fnvd_dp.sv
// ----------------------------------------------------------------------------
// fnvd_dp
// Datapath: hash state, byte shifter, mix registers and one shared
// 32x32 multiplier for the high-half mix.
// ----------------------------------------------------------------------------
module fnvd_dp #(
    parameter int MAX_BYTES_PER_ITEM = fnvd_pkg::MAX_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fnvd_pkg::t_dp_cmd             i_cmd,
    input  logic [fnvd_pkg::DATA_W-1:0]   i_data,
    input  logic [fnvd_pkg::COUNT_W-1:0]  i_count,
    input  logic                          i_last,
    output fnvd_pkg::t_dp_sts             o_sts,
    output logic [63:0]                   o_digest_lo,
    output logic [63:0]                   o_digest_hi
);
    import fnvd_pkg::*;

    localparam int DataW = MAX_BYTES_PER_ITEM * 8;
    localparam int CntW  = $clog2(MAX_BYTES_PER_ITEM + 1);

    logic [63:0]      r_hash;
    logic [DataW-1:0] r_data;
    logic [CntW-1:0]  r_cnt;
    logic             r_last;
    logic [63:0]      r_mix;
    logic [63:0]      r_acc;
    logic [63:0]      r_dig_lo;
    logic [63:0]      r_dig_hi;

    logic [CntW-1:0]  load_cnt;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;

    assign load_cnt = (i_count > COUNT_W'(MAX_BYTES_PER_ITEM)) ?
                      CntW'(MAX_BYTES_PER_ITEM) : i_count[CntW-1:0];

    assign mul_a = (i_cmd.op == OP_MUL2) ? r_mix[63:32] : r_mix[31:0];
    assign mul_b = (i_cmd.op == OP_MUL1) ? MIX_MULT[63:32] : MIX_MULT[31:0];
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_one  = (r_cnt == CntW'(1));
    assign o_sts.last     = r_last;
    assign o_digest_lo    = r_dig_lo;
    assign o_digest_hi    = r_dig_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
        end else begin
            unique case (i_cmd.op)
                OP_ABSORB: r_hash <= fnv_absorb(r_hash, r_data[7:0]);
                OP_FINISH: r_hash <= FNV_BASIS;
                default:   r_hash <= r_hash;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_data <= i_data[DataW-1:0];
                r_cnt  <= load_cnt;
                r_last <= i_last;
            end
            OP_ABSORB: begin
                r_data <= r_data >> 8;
                r_cnt  <= r_cnt - CntW'(1);
            end
            OP_MIX: r_mix <= mix_pre(r_hash);
            OP_MUL0: r_acc <= mul_p;
            OP_MUL1: r_acc <= r_acc + {mul_p[31:0], 32'b0};
            OP_MUL2: r_acc <= r_acc + {mul_p[31:0], 32'b0};
            OP_FINISH: begin
                r_dig_lo <= r_hash;
                r_dig_hi <= r_acc ^ (r_acc >> MIX_SHIFT_B) ^ FNV_BASIS;
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hdl/canonical_fnv1a_digest.sv
// ----------------------------------------------------------------------------
// canonical_fnv1a_digest
// FNV-1a 64 absorber over a byte stream with a 128-bit digest on the last beat.
// ----------------------------------------------------------------------------
// An input beat carrying N bytes (byte_count saturated to MAX_BYTES_PER_ITEM)
// is loaded into the byte shifter and absorbed a byte at a time through the
// dependent xor-and-prime-multiply on the hash register. A beat with tlast set
// then runs the high-half mix, whose 64-bit product runs as three
// partial products through one 32x32 multiplier, and then loads the digest
// into the output register, where it waits while further beats are absorbed.
// tready is high only while no beat is being absorbed. After reset the hash
// holds the FNV-1a offset basis, and it returns there after each digest.
module canonical_fnv1a_digest #(
    parameter int MAX_BYTES_PER_ITEM = fnvd_pkg::MAX_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [fnvd_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // data_bytes, byte_count, pad
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [fnvd_pkg::OUT_TDATA_W-1:0]  o_m_tdata   // digest_lo, digest_hi
);
    import fnvd_pkg::*;

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [63:0] digest_lo;
    logic [63:0] digest_hi;

    fnvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fnvd_dp #(
        .MAX_BYTES_PER_ITEM (MAX_BYTES_PER_ITEM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data      (i_s_tdata[DATA_W-1:0]),
        .i_count     (i_s_tdata[DATA_W+COUNT_W-1:DATA_W]),
        .i_last      (i_s_tlast),
        .o_sts       (sts),
        .o_digest_lo (digest_lo),
        .o_digest_hi (digest_hi)
    );

    assign o_m_tdata = {digest_hi, digest_lo};

endmodule
